[src/bilinear_map_lookup_top_defines.svh]
// assertion macros shared by the lookup rtl
`ifndef BILINEAR_MAP_LOOKUP_TOP_DEFINES_SVH
`define BILINEAR_MAP_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BML_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BML_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bml_pkg.sv]
package bml_pkg;

    // map geometry and number formats
    localparam int ROWS        = 16;
    localparam int COLS        = 16;
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int AXIS_LEN    = ROWS;
    localparam int AXIS_W      = 16;
    localparam int CELL_W      = 4;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int FRAC_STEPS  = FRAC_BITS + 1;
    localparam int STEPS_PER   = 2;
    localparam int DIV_STAGES  = (FRAC_STEPS + STEPS_PER - 1) / STEPS_PER;
    localparam int BANK_DEPTH  = (ROWS / 2) * (COLS / 2);
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int PROD_W      = DATA_WIDTH + FRAC_W;
    localparam int BLEND_W     = PROD_W;
    localparam int ACC_W       = BLEND_W + FRAC_W;
    localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        FUNC_WR_X   = 2'd0,
        FUNC_WR_Y   = 2'd1,
        FUNC_WR_TBL = 2'd2,
        FUNC_LOOKUP = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [7:0]  entry_index;
        logic [15:0] write_value;
        logic [15:0] x_value;
        logic [15:0] y_value;
    } t_in_word;

    typedef struct packed {
        logic [15:0] interp_value;
        logic [3:0]  row_cell;
        logic [3:0]  col_cell;
        logic        x_clamped;
        logic        y_clamped;
    } t_out_word;

    // write request toward one store
    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [15:0] data;
    } t_wr_port;

    // cell and fraction found on one axis
    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic [FRAC_W-1:0] frac;
        logic              clamped;
    } t_axis_res;

    // per-item flags carried through the divider
    typedef struct packed {
        logic              below;
        logic              nonpos;
        logic              big;
        logic [CELL_W-1:0] cell_idx;
    } t_div_tag;

endpackage

[src/bml_axis.sv]
`include "bilinear_map_lookup_top_defines.svh"

module bml_axis (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [15:0]         i_value,
    input  bml_pkg::t_wr_port   i_wr,
    output logic                o_valid,
    output bml_pkg::t_axis_res  o_res,
    output logic                o_busy
);
    import bml_pkg::*;

    localparam int NCMP = AXIS_LEN - 1;

    // breakpoints: flops for the compare, two memories for the cell bounds
    logic [AXIS_W-1:0] r_axis [AXIS_LEN];
    logic [AXIS_W-1:0] r_lo_mem [AXIS_LEN];
    logic [AXIS_W-1:0] r_hi_mem [AXIS_LEN];

    logic [CELL_W-1:0] wr_pos;
    logic              wr_hit;
    assign wr_pos = i_wr.idx[CELL_W-1:0];
    assign wr_hit = i_wr.en && (i_wr.idx < 8'(AXIS_LEN));

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_axis[wr_pos]   <= i_wr.data;
            r_lo_mem[wr_pos] <= i_wr.data;
            if (wr_pos != '0) begin
                r_hi_mem[wr_pos - 1'b1] <= i_wr.data;
            end
        end
    end

    // stage a1: compare against every breakpoint but the last
    logic [NCMP-1:0]   n_ge;
    logic [NCMP-1:0]   r_ge;
    logic [AXIS_W-1:0] r_v1;
    logic              r_vld1;

    always_comb begin
        for (int i = 0; i < NCMP; i++) begin
            n_ge[i] = i_value >= r_axis[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ge <= n_ge;
            r_v1 <= i_value;
        end
    end

    // stage a2: last breakpoint reached, read cell bounds
    logic [CELL_W-1:0] n_cell;
    logic [CELL_W-1:0] r_cell2;
    logic [AXIS_W-1:0] r_v2;
    logic [AXIS_W-1:0] r_lo2;
    logic [AXIS_W-1:0] r_hi2;
    logic              r_vld2;

    always_comb begin
        n_cell = '0;
        for (int i = 0; i < NCMP; i++) begin
            if (r_ge[i]) begin
                n_cell = CELL_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell2 <= n_cell;
            r_v2    <= r_v1;
            r_lo2   <= r_lo_mem[n_cell];
            r_hi2   <= r_hi_mem[n_cell];
        end
    end

    // stage a3: offset, gap and range flags
    logic              r_dv  [DIV_STAGES+1];
    logic [16:0]       r_rem [DIV_STAGES+1];
    logic [FRAC_W-1:0] r_q   [DIV_STAGES+1];
    logic [15:0]       r_gap [DIV_STAGES+1];
    t_div_tag          r_tag [DIV_STAGES+1];

    logic [15:0] n_d;
    logic [15:0] n_gap;
    assign n_d   = r_v2 - r_lo2;
    assign n_gap = r_hi2 - r_lo2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]          <= {1'b0, n_d};
            r_q[0]            <= '0;
            r_gap[0]          <= n_gap;
            r_tag[0].below    <= r_v2 < r_lo2;
            r_tag[0].nonpos   <= r_hi2 <= r_lo2;
            r_tag[0].big      <= {1'b0, n_d} >= {n_gap, 1'b0};
            r_tag[0].cell_idx <= r_cell2;
        end
    end

    // restoring divider, two quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [16:0]       c_rem;
        logic [FRAC_W-1:0] c_q;

        always_comb begin
            logic [16:0]       rem;
            logic [FRAC_W-1:0] q;
            logic              qb;
            rem = r_rem[k];
            q   = r_q[k];
            qb  = 1'b0;
            for (int s = 0; s < STEPS_PER; s++) begin
                if (k * STEPS_PER + s < FRAC_STEPS) begin
                    qb = rem >= {1'b0, r_gap[k]};
                    if (qb) begin
                        rem = rem - {1'b0, r_gap[k]};
                    end
                    rem = {rem[15:0], 1'b0};
                    q   = {q[FRAC_W-2:0], qb};
                end
            end
            c_rem = rem;
            c_q   = q;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= c_rem;
                r_q[k+1]   <= c_q;
                r_gap[k+1] <= r_gap[k];
                r_tag[k+1] <= r_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // final stage: clamp the fraction
    t_div_tag          last_tag;
    logic [FRAC_W-1:0] last_q;
    logic              over;
    t_axis_res         n_res;
    t_axis_res         r_res;
    logic              r_vld_out;

    assign last_tag = r_tag[DIV_STAGES];
    assign last_q   = r_q[DIV_STAGES];
    assign over     = last_tag.big || (last_q > ONE_FRAC);

    always_comb begin
        n_res.cell_idx = last_tag.cell_idx;
        if (last_tag.below) begin
            n_res.frac    = '0;
            n_res.clamped = 1'b1;
        end else if (last_tag.nonpos) begin
            n_res.frac    = '0;
            n_res.clamped = 1'b0;
        end else if (over) begin
            n_res.frac    = ONE_FRAC;
            n_res.clamped = 1'b1;
        end else begin
            n_res.frac    = last_q;
            n_res.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    // valid bits of the front stages and the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_dv[0]   <= 1'b0;
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld1    <= i_valid;
            r_vld2    <= r_vld1;
            r_dv[0]   <= r_vld2;
            r_vld_out <= r_dv[DIV_STAGES];
        end
    end

    logic div_busy;
    always_comb begin
        div_busy = 1'b0;
        for (int k = 0; k <= DIV_STAGES; k++) begin
            div_busy = div_busy | r_dv[k];
        end
    end

    assign o_valid = r_vld_out;
    assign o_res   = r_res;
    assign o_busy  = r_vld1 | r_vld2 | div_busy | r_vld_out;

    `BML_ASSERT_NOW(a_clamp_frac, r_vld_out && r_res.clamped, (r_res.frac == '0) || (r_res.frac == ONE_FRAC), "clamped fraction not at an end")
    `BML_ASSERT_NOW(a_frac_range, r_vld_out, r_res.frac <= ONE_FRAC, "fraction above one")
    `BML_ASSERT_NOW(a_cell_range, r_vld_out, r_res.cell_idx <= CELL_W'(AXIS_LEN - 2), "cell past second-to-last breakpoint")

endmodule

[src/bml_blend.sv]
`include "bilinear_map_lookup_top_defines.svh"

module bml_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bml_pkg::t_axis_res  i_x,
    input  bml_pkg::t_axis_res  i_y,
    input  bml_pkg::t_wr_port   i_wr,
    output logic                o_valid,
    output bml_pkg::t_out_word  o_word
);
    import bml_pkg::*;

    // table split in four banks by row and column parity
    logic [DATA_WIDTH-1:0] r_bank [4][BANK_DEPTH];
    logic [3:0]            wr_row;
    logic [3:0]            wr_col;
    logic [1:0]            wr_bank;
    logic [BANK_AW-1:0]    wr_addr;

    assign wr_row  = i_wr.idx[7:4];
    assign wr_col  = i_wr.idx[3:0];
    assign wr_bank = {wr_row[0], wr_col[0]};
    assign wr_addr = {wr_row[3:1], wr_col[3:1]};

    always_ff @(posedge i_clk) begin
        if (i_wr.en && ({1'b0, i_wr.idx} < 9'(ROWS * COLS))) begin
            r_bank[wr_bank][wr_addr] <= i_wr.data[DATA_WIDTH-1:0];
        end
    end

    // stage t: read the four corners
    logic [DATA_WIDTH-1:0] r_dat [4];
    logic                  r_r0;
    logic                  r_c0;
    logic [FRAC_W-1:0]     r_fx_t;
    logic [FRAC_W-1:0]     r_fy_t;
    logic [11:0]           r_tag_t;
    logic [11:0]           r_tag_1;
    logic [11:0]           r_tag_2;
    logic [11:0]           r_tag_3;
    logic [4:0]            r_vld;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [3:0]         rr;
        logic [3:0]         cc;
        logic [BANK_AW-1:0] rd_addr;

        assign rr      = (i_x.cell_idx[0] == 1'(b / 2)) ? i_x.cell_idx : i_x.cell_idx + 1'b1;
        assign cc      = (i_y.cell_idx[0] == 1'(b % 2)) ? i_y.cell_idx : i_y.cell_idx + 1'b1;
        assign rd_addr = {rr[3:1], cc[3:1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dat[b] <= r_bank[b][rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r0    <= i_x.cell_idx[0];
            r_c0    <= i_y.cell_idx[0];
            r_fx_t  <= i_x.frac;
            r_fy_t  <= i_y.frac;
            r_tag_t <= {i_x.cell_idx, i_y.cell_idx, i_x.clamped, i_y.clamped, 2'b00};
        end
    end

    // stage m1: weight along the column axis
    logic [DATA_WIDTH-1:0] v00, v01, v10, v11;
    logic [FRAC_W-1:0]     wy0;
    logic [PROD_W-1:0]     r_p00, r_p01, r_p10, r_p11;
    logic [FRAC_W-1:0]     r_fx_1;

    assign v00 = r_dat[{r_r0, r_c0}];
    assign v01 = r_dat[{r_r0, ~r_c0}];
    assign v10 = r_dat[{~r_r0, r_c0}];
    assign v11 = r_dat[{~r_r0, ~r_c0}];
    assign wy0 = ONE_FRAC - r_fy_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= PROD_W'(v00 * wy0);
            r_p01   <= PROD_W'(v01 * r_fy_t);
            r_p10   <= PROD_W'(v10 * wy0);
            r_p11   <= PROD_W'(v11 * r_fy_t);
            r_fx_1  <= r_fx_t;
            r_tag_1 <= r_tag_t;
        end
    end

    // stage m2: blend each row pair
    logic [BLEND_W-1:0] r_a0, r_a1;
    logic [FRAC_W-1:0]  r_fx_2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0    <= r_p00 + r_p01;
            r_a1    <= r_p10 + r_p11;
            r_fx_2  <= r_fx_1;
            r_tag_2 <= r_tag_1;
        end
    end

    // stage m3: weight along the row axis
    logic [ACC_W-1:0] r_q0, r_q1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0    <= ACC_W'(r_a0 * (ONE_FRAC - r_fx_2));
            r_q1    <= ACC_W'(r_a1 * r_fx_2);
            r_tag_3 <= r_tag_2;
        end
    end

    // stage m4: sum, round half up, output word
    logic [ACC_W:0] n_sum;
    t_out_word      r_word;

    assign n_sum = {1'b0, r_q0} + {1'b0, r_q1} + ((ACC_W+1)'(1) << (2 * FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.interp_value <= n_sum[2*FRAC_BITS +: 16];
            r_word.row_cell     <= r_tag_3[11:8];
            r_word.col_cell     <= r_tag_3[7:4];
            r_word.x_clamped    <= r_tag_3[3];
            r_word.y_clamped    <= r_tag_3[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_word  = r_word;

    `BML_ASSERT_NOW(a_tag_pad, r_vld[0], r_tag_t[1:0] == 2'b00, "tag padding corrupted")
    `BML_ASSERT_NXT(a_hold, !i_en && r_vld[4], r_vld[4] && $stable(r_word), "result lost during stall")
    `BML_ASSERT_NOW(a_corner_wt, r_vld[1], r_fx_1 <= ONE_FRAC, "row weight above one")

endmodule

[src/bilinear_map_lookup_top.sv]
// bilinear map lookup, pipelined
// a lookup passes the input register, both axis locators and the blend stages to the output
// throughput: one lookup per cycle if not stalled; the divider (two quotient bits per stage)
// sets the depth; a write word waits until no lookup remains ahead of the table read,
// and an output stall holds it too; reset (synchronous, active low) clears every valid bit
// axes and table stay undefined until written

`include "bilinear_map_lookup_top_defines.svh"

module bilinear_map_lookup_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bml_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bml_pkg::t_out_word  o_out_word
);
    import bml_pkg::*;

    // one stall signal for the whole pipeline
    logic en;
    logic busy;
    logic accept;
    logic is_lookup;

    assign en         = !o_out_valid || i_out_ready;
    assign is_lookup  = i_in_word.func == FUNC_LOOKUP;
    assign o_in_ready = en && (is_lookup || !busy);
    assign accept     = i_in_valid && o_in_ready;

    // write ports
    t_wr_port wr_x, wr_y, wr_t;

    always_comb begin
        wr_x.en   = accept && (i_in_word.func == FUNC_WR_X);
        wr_x.idx  = i_in_word.entry_index;
        wr_x.data = i_in_word.write_value;
        wr_y.en   = accept && (i_in_word.func == FUNC_WR_Y);
        wr_y.idx  = i_in_word.entry_index;
        wr_y.data = i_in_word.write_value;
        wr_t.en   = accept && (i_in_word.func == FUNC_WR_TBL);
        wr_t.idx  = i_in_word.entry_index;
        wr_t.data = i_in_word.write_value;
    end

    // input register for lookups
    logic        r_s1_vld;
    logic [15:0] r_s1_x;
    logic [15:0] r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept && is_lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x <= i_in_word.x_value;
            r_s1_y <= i_in_word.y_value;
        end
    end

    // one locator per axis
    logic      x_vld, y_vld, x_busy, y_busy;
    t_axis_res x_res, y_res;

    bml_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_value (r_s1_x),
        .i_wr    (wr_x),
        .o_valid (x_vld),
        .o_res   (x_res),
        .o_busy  (x_busy)
    );

    bml_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_value (r_s1_y),
        .i_wr    (wr_y),
        .o_valid (y_vld),
        .o_res   (y_res),
        .o_busy  (y_busy)
    );

    assign busy = r_s1_vld | x_busy | y_busy;

    // corner read and blend
    bml_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_vld),
        .i_x     (x_res),
        .i_y     (y_res),
        .i_wr    (wr_t),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    `BML_ASSERT_NOW(a_wr_no_inflight, i_in_valid && o_in_ready && !is_lookup, !busy, "write taken with lookup in flight")
    `BML_ASSERT_NOW(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready, "input taken during output stall")
    `BML_ASSERT_NOW(a_axes_aligned, 1'b1, x_vld == y_vld, "axis pipelines out of step")

endmodule

[dv/bilinear_map_lookup_top_test.sv]
module bilinear_map_lookup_top_test;
    import bml_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    bilinear_map_lookup_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mirrored map contents
    logic [15:0] pred_x_axis [ROWS];
    logic [15:0] pred_y_axis [COLS];
    logic [15:0] pred_map [ROWS*COLS];

    t_out_word pending_results[$];
    int        mismatches = 0;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;
    int        items_sent = 0;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    t_row rows[$];

    // locate cell and q1.12 fraction on one axis
    task automatic find_cell(input logic [15:0] ax[16], input logic [15:0] v,
                             output logic [3:0] cell_idx, output longint unsigned frac,
                             output logic clamped);
        int c;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned q;
        c = 0;
        for (int i = 0; i < 15; i++)
            if (v >= ax[i]) c = i;
        cell_idx = c[3:0];
        lo = ax[c];
        hi = ax[c+1];
        if (v < lo) begin
            frac = 0;
            clamped = 1'b1;
        end else if (hi <= lo) begin
            frac = 0;
            clamped = 1'b0;
        end else begin
            q = ((longint'(v) - lo) << FRAC_BITS) / (hi - lo);
            if (q > (64'd1 << FRAC_BITS)) begin
                frac = 64'd1 << FRAC_BITS;
                clamped = 1'b1;
            end else begin
                frac = q;
                clamped = 1'b0;
            end
        end
    endtask

    // bilinear blend of the four corners, rounded half up
    task automatic blend_lookup(input logic [15:0] xv, input logic [15:0] yv,
                                output t_out_word r);
        logic [3:0] rc, cc;
        longint unsigned fx, fy, one, acc;
        logic cx, cy;
        int rr, ci;
        one = 64'd1 << FRAC_BITS;
        find_cell(pred_x_axis, xv, rc, fx, cx);
        find_cell(pred_y_axis, yv, cc, fy, cy);
        rr = rc;
        ci = cc;
        acc = pred_map[rr*COLS+ci] * (one - fx) * (one - fy)
            + pred_map[(rr+1)*COLS+ci] * fx * (one - fy)
            + pred_map[rr*COLS+ci+1] * (one - fx) * fy
            + pred_map[(rr+1)*COLS+ci+1] * fx * fy;
        acc = (acc + (64'd1 << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
        r.interp_value = acc[15:0];
        r.row_cell = rc;
        r.col_cell = cc;
        r.x_clamped = cx;
        r.y_clamped = cy;
    endtask

    // apply one accepted word to the mirror, returning its result if any
    task automatic apply_word(input t_in_word w, output bit has_res, output t_out_word r);
        has_res = 1'b0;
        r = '0;
        case (w.func)
            FUNC_WR_X: begin
                if (w.entry_index < ROWS) pred_x_axis[w.entry_index] = w.write_value;
            end
            FUNC_WR_Y: begin
                if (w.entry_index < COLS) pred_y_axis[w.entry_index] = w.write_value;
            end
            FUNC_WR_TBL: begin
                pred_map[w.entry_index] = w.write_value;
            end
            default: begin
                blend_lookup(w.x_value, w.y_value, r);
                has_res = 1'b1;
            end
        endcase
    endtask

    function automatic t_in_word wr(t_func f, logic [7:0] idx, logic [15:0] val);
        t_in_word w;
        w = '0;
        w.func = f;
        w.entry_index = idx;
        w.write_value = val;
        w.x_value = 16'($urandom);
        w.y_value = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word lk(logic [15:0] xv, logic [15:0] yv);
        t_in_word w;
        w.func = FUNC_LOOKUP;
        w.entry_index = 8'($urandom);
        w.write_value = 16'($urandom);
        w.x_value = xv;
        w.y_value = yv;
        return w;
    endfunction

    function automatic t_out_word res(logic [15:0] v, logic [3:0] rc, logic [3:0] cc,
                                      logic cx, logic cy);
        t_out_word r;
        r.interp_value = v;
        r.row_cell = rc;
        r.col_cell = cc;
        r.x_clamped = cx;
        r.y_clamped = cy;
        return r;
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        bit has_res;
        t_out_word r;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        apply_word(w, has_res, r);
        if (has_res) pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // random sender gap
    task automatic maybe_gap();
        if (!quiet && ($urandom % 5 == 0)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send(input t_in_word w);
        maybe_gap();
        send_word(w, 1'b0, '0);
    endtask

    // load a strictly increasing axis
    task automatic load_axis(input t_func f);
        logic [15:0] v;
        int step_max;
        step_max = ($urandom % 4 == 0) ? 3 : 4000;
        v = 16'($urandom_range(0, 3000));
        for (int i = 0; i < 16; i++) begin
            send(wr(f, 8'(i), v));
            v = 16'(v + $urandom_range(1, step_max));
        end
    endtask

    // receiver: random stalls plus long hold-offs while hold_req is set
    initial begin
        out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && ($urandom % 6 == 0)) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10) $display("unexpected result word %h", out_word);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (out_word !== e) begin
                    if (mismatches < 10)
                        $display({"mismatch: exp val %0d row %0d col %0d cx %0d cy %0d,",
                                  " got val %0d row %0d col %0d cx %0d cy %0d"},
                                 e.interp_value, e.row_cell, e.col_cell, e.x_clamped,
                                 e.y_clamped, out_word.interp_value, out_word.row_cell,
                                 out_word.col_cell, out_word.x_clamped, out_word.y_clamped);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial begin
        #(12 * 600000);
        $display("bilinear_map_lookup_top_test: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        int r;
        logic [15:0] xv, yv;
        in_valid <= 1'b0;
        in_word <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every store before any lookup
        for (int i = 0; i < 16; i++) send(wr(FUNC_WR_X, 8'(i), 16'(1000 + 4000*i)));
        for (int i = 0; i < 16; i++) send(wr(FUNC_WR_Y, 8'(i), 16'(2000 + 3000*i)));
        for (int i = 0; i < ROWS*COLS; i++) send(wr(FUNC_WR_TBL, 8'(i), 16'(200*i)));

        // directed: clamps, extremes, ignored writes, zero and negative gaps
        rows.push_back('{lk(0, 0), 1, res(0, 0, 0, 1, 1)});
        rows.push_back('{lk(16'hffff, 16'hffff), 1, res(51000, 14, 14, 1, 1)});
        rows.push_back('{lk(1000, 2000), 0, '0});
        rows.push_back('{lk(3000, 3500), 0, '0});
        rows.push_back('{wr(FUNC_WR_TBL, 0, 16'hffff), 0, '0});
        rows.push_back('{lk(0, 0), 1, res(16'hffff, 0, 0, 1, 1)});
        rows.push_back('{wr(FUNC_WR_TBL, 255, 0), 0, '0});
        rows.push_back('{lk(16'hffff, 16'hffff), 1, res(0, 14, 14, 1, 1)});
        rows.push_back('{wr(FUNC_WR_X, 200, 0), 0, '0});
        rows.push_back('{wr(FUNC_WR_Y, 16, 0), 0, '0});
        rows.push_back('{lk(0, 0), 1, res(16'hffff, 0, 0, 1, 1)});
        rows.push_back('{wr(FUNC_WR_X, 15, 57000), 0, '0});
        rows.push_back('{lk(60000, 10000), 0, '0});
        rows.push_back('{wr(FUNC_WR_Y, 5, 9000), 0, '0});
        rows.push_back('{lk(30000, 12000), 0, '0});
        rows.push_back('{lk(30000, 15000), 0, '0});
        rows.push_back('{wr(FUNC_WR_X, 15, 61000), 0, '0});
        rows.push_back('{wr(FUNC_WR_Y, 5, 17000), 0, '0});
        rows.push_back('{wr(FUNC_WR_TBL, 0, 0), 0, '0});
        rows.push_back('{wr(FUNC_WR_TBL, 255, 51000), 0, '0});
        rows.push_back('{lk(61000, 47000), 0, '0});
        rows.push_back('{lk(5000, 8000), 0, '0});
        foreach (rows[i]) begin
            maybe_gap();
            send_word(rows[i].w, rows[i].typed, rows[i].res);
        end

        // random: mostly lookups, over axes that random axis writes can disorder
        while (items_sent < 1950) begin
            if (items_sent > 1750) quiet = 1'b1;
            if (items_sent > 600 && items_sent < 620) hold_req = 1'b1;
            r = $urandom % 100;
            if (r < 72) begin
                if ($urandom % 2) begin
                    xv = 16'($urandom);
                    yv = 16'($urandom);
                end else begin
                    xv = 16'(pred_x_axis[$urandom % 16] + $urandom_range(0, 40) - 20);
                    yv = 16'(pred_y_axis[$urandom % 16] + $urandom_range(0, 40) - 20);
                end
                send(lk(xv, yv));
            end else if (r < 86) begin
                send(wr(FUNC_WR_TBL, 8'($urandom), 16'($urandom)));
            end else if (r < 94) begin
                send(wr($urandom % 2 ? FUNC_WR_X : FUNC_WR_Y, 8'($urandom), 16'($urandom)));
            end else if (r < 97) begin
                load_axis(FUNC_WR_X);
            end else begin
                load_axis(FUNC_WR_Y);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bilinear_map_lookup_top_test: done, clean");
        end else begin
            $display("bilinear_map_lookup_top_test: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/bml_pkg.sv
src/bml_axis.sv
src/bml_blend.sv
src/bilinear_map_lookup_top.sv
dv/bilinear_map_lookup_top_test.sv
